/* hdl/hlf_pkg.sv */
// ----------------------------------------------------------------------------
// hlf_pkg: shared types and constants of the histogram localization filter
// Opcodes, register indexes and reset values imported by the divider and the filter.
// ----------------------------------------------------------------------------
package hlf_pkg;

  localparam int unsigned MaxCellsDef = 32;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  typedef enum logic [1:0] {
    OP_SENSE   = 2'd0,
    OP_MOVE    = 2'd1,
    OP_MAP_WR  = 2'd2,
    OP_UNIFORM = 2'd3
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CELLS = 3'd0,
    REG_HIT   = 3'd1,
    REG_MISS  = 3'd2,
    REG_EXACT = 3'd3,
    REG_OVER  = 3'd4,
    REG_UNDER = 3'd5
  } cfg_reg_e;

  localparam logic [5:0]  CellsRst = 6'd5;
  localparam logic [15:0] HitRst   = 16'd39322;
  localparam logic [15:0] MissRst  = 16'd13107;
  localparam logic [15:0] ExactRst = 16'd52429;
  localparam logic [15:0] OverRst  = 16'd6554;
  localparam logic [15:0] UnderRst = 16'd6554;

endpackage

/* hdl/hlf_ram.sv */
// ----------------------------------------------------------------------------
// hlf_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hlf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hdl/hlf_div.sv */
// ----------------------------------------------------------------------------
// hlf_div: restoring divider, one quotient bit per cycle
// Divides a 49-bit numerator by a 38-bit divisor, saturates to 16 bits.
// ----------------------------------------------------------------------------
module hlf_div
  import hlf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [48:0] num_i,
  input  logic [37:0] den_i,
  output logic        busy_o,
  output logic [15:0] quot_o
);
  logic [48:0] num_q, num_d;
  logic [38:0] rem_q, rem_d;
  logic [16:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [38:0] trial;

  // Quotient only needs 17 bits (then saturate); upper bits just prime remainder
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = '0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 6'd49;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[37:0], num_q[48]};
      num_d = {num_q[47:0], 1'b0};
      if (trial >= {1'b0, den_i}) begin
        rem_d = trial - {1'b0, den_i};
        quo_d = (quo_q == 17'h1ffff) ? quo_q : {quo_q[15:0], 1'b1} | {quo_q[16], 16'd0};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[15:0], 1'b0} | {quo_q[16], 16'd0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // Sticky top bit marks overflow past 16 bits
  assign busy_o = busy_q;
  assign quot_o = quo_q[16] ? 16'hffff : quo_q[15:0];

  property p_cnt_idle;
    @(posedge clk_i) disable iff (!rst_ni) !busy_q |-> cnt_q == 6'd0;
  endproperty
  a_cnt_idle: assert property (p_cnt_idle) else $error("div count left over");

  property p_done;
    @(posedge clk_i) disable iff (!rst_ni)
      busy_q && !start_i && cnt_q == 6'd1 |=> !busy_q;
  endproperty
  a_done: assert property (p_done) else $error("div did not finish");

  property p_start;
    @(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_q && cnt_q == 6'd49;
  endproperty
  a_start: assert property (p_start) else $error("div start lost");
endmodule

/* hdl/histogram_localization_filter.sv */
// Sense forms a product per cell (S_SRD, S_SMUL, S_SACC), then divides and emits
// one item per cell; a zero sum skips the divides. Move makes three multiplier
// passes and a staging writeback per cell, then emits one item per cell.
// Map write does not hold the input off; uniform reset holds it off over its sweep.
// After reset a sweep over all MAX_CELLS entries loads uniform beliefs; no item is taken
// meanwhile. Each result item is held in an output register until taken.
// ----------------------------------------------------------------------------
// histogram_localization_filter: 1-D Markov localization over a cyclic map
// Sequencer around a shared multiplier, belief/color/scratch/staging RAMs and divider.
// ----------------------------------------------------------------------------
module histogram_localization_filter
  import hlf_pkg::*;
#(
  parameter int unsigned MAX_CELLS = MaxCellsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          color_i,
  input  logic signed [5:0]   shift_i,
  input  logic [4:0]          cell_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [4:0]          cell_index_o,
  output logic [15:0]         belief_o,
  output logic                zero_sum_o,
  output logic                last_o
);
  localparam int unsigned AW = $clog2(MAX_CELLS);
  localparam int unsigned CntW = AW + 1;
  localparam int unsigned NCap = (MAX_CELLS < 32) ? MAX_CELLS : 32;

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_UNI   = 14'b00000000000100,
    S_SRD   = 14'b00000000001000,
    S_SMUL  = 14'b00000000010000,
    S_SACC  = 14'b00000000100000,
    S_DRD   = 14'b00000001000000,
    S_DIV   = 14'b00000010000000,
    S_DWAIT = 14'b00000100000000,
    S_MRD   = 14'b00001000000000,
    S_MMUL  = 14'b00010000000000,
    S_MWR   = 14'b00100000000000,
    S_EMIT  = 14'b01000000000000,
    S_EOUT  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // Config registers
  logic [5:0]  cells_q;
  logic [15:0] hit_q, miss_q, exact_q, over_q, under_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_q <= CellsRst; hit_q <= HitRst; miss_q <= MissRst;
      exact_q <= ExactRst; over_q <= OverRst; under_q <= UnderRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CELLS: cells_q <= cfg_data_i[5:0];
        REG_HIT:   hit_q   <= cfg_data_i;
        REG_MISS:  miss_q  <= cfg_data_i;
        REG_EXACT: exact_q <= cfg_data_i;
        REG_OVER:  over_q  <= cfg_data_i;
        REG_UNDER: under_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Active cell count, clamped
  logic [5:0] n_act;
  always_comb begin
    n_act = cells_q;
    if (cells_q == 6'd0) n_act = 6'd1;
    if ({26'd0, cells_q} > NCap) n_act = 6'(NCap);
  end
  logic [CntW-1:0] n_c;
  assign n_c = CntW'(n_act);

  // Uniform value: floor(65536/n) from a table on clamped n, 65535 for one cell
  logic [15:0] uni_val;
  always_comb begin
    case (n_act)
      6'd1:    uni_val = 16'd65535;
      6'd2:    uni_val = 16'd32768;
      6'd3:    uni_val = 16'd21845;
      6'd4:    uni_val = 16'd16384;
      6'd5:    uni_val = 16'd13107;
      6'd6:    uni_val = 16'd10922;
      6'd7:    uni_val = 16'd9362;
      6'd8:    uni_val = 16'd8192;
      6'd9:    uni_val = 16'd7281;
      6'd10:   uni_val = 16'd6553;
      6'd11:   uni_val = 16'd5957;
      6'd12:   uni_val = 16'd5461;
      6'd13:   uni_val = 16'd5041;
      6'd14:   uni_val = 16'd4681;
      6'd15:   uni_val = 16'd4369;
      6'd16:   uni_val = 16'd4096;
      6'd17:   uni_val = 16'd3855;
      6'd18:   uni_val = 16'd3640;
      6'd19:   uni_val = 16'd3449;
      6'd20:   uni_val = 16'd3276;
      6'd21:   uni_val = 16'd3120;
      6'd22:   uni_val = 16'd2978;
      6'd23:   uni_val = 16'd2849;
      6'd24:   uni_val = 16'd2730;
      6'd25:   uni_val = 16'd2621;
      6'd26:   uni_val = 16'd2520;
      6'd27:   uni_val = 16'd2427;
      6'd28:   uni_val = 16'd2340;
      6'd29:   uni_val = 16'd2259;
      6'd30:   uni_val = 16'd2184;
      6'd31:   uni_val = 16'd2114;
      default: uni_val = 16'd2048;
    endcase
  end

  // Memories
  logic          bel_we, col_we, scr_we, mv_we;
  logic [AW-1:0] bel_wa, bel_ra, col_wa, col_ra, scr_wa, scr_ra, mv_wa, mv_ra;
  logic [15:0]   bel_wd, bel_rd, mv_wd, mv_rd;
  logic [7:0]    col_wd, col_rd;
  logic [31:0]   scr_wd, scr_rd;

  hlf_ram #(.Width(16), .Depth(MAX_CELLS)) u_bel (
    .clk_i, .we_i(bel_we), .waddr_i(bel_wa), .wdata_i(bel_wd),
    .raddr_i(bel_ra), .rdata_o(bel_rd));
  hlf_ram #(.Width(8), .Depth(MAX_CELLS)) u_col (
    .clk_i, .we_i(col_we), .waddr_i(col_wa), .wdata_i(col_wd),
    .raddr_i(col_ra), .rdata_o(col_rd));
  hlf_ram #(.Width(32), .Depth(MAX_CELLS)) u_scr (
    .clk_i, .we_i(scr_we), .waddr_i(scr_wa), .wdata_i(scr_wd),
    .raddr_i(scr_ra), .rdata_o(scr_rd));
  // Move results go to a staging copy, then copied back during emit
  hlf_ram #(.Width(16), .Depth(MAX_CELLS)) u_mv (
    .clk_i, .we_i(mv_we), .waddr_i(mv_wa), .wdata_i(mv_wd),
    .raddr_i(mv_ra), .rdata_o(mv_rd));

  // Datapath registers
  logic [CntW-1:0] idx_q, idx_d, clr_q, clr_d;
  logic [1:0]      tap_q, tap_d;
  logic [7:0]      color_q, color_d;
  logic [AW-1:0]   src_q, src_d;
  logic [37:0]     sum_q, sum_d;
  logic [33:0]     acc_q, acc_d;
  logic [31:0]     prod_q;
  logic            zero_q, zero_d, is_move_q, is_move_d;
  logic [15:0]     mul_a, mul_b;
  logic            ov_q, ov_d;
  logic [4:0]      oidx_d;
  logic [15:0]     obel_d;
  logic            olast_d, ovld_d, ovld_q;

  // Divider
  logic        div_start, div_busy;
  logic [48:0] div_num;
  logic [15:0] div_q;
  hlf_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
    .den_i(sum_q), .busy_o(div_busy), .quot_o(div_q));

  // Shared multiplier, registered
  always_ff @(posedge clk_i) prod_q <= mul_a * mul_b;

  // Modular index helper
  function automatic logic [AW-1:0] wrap_add(input logic [CntW-1:0] a,
                                             input logic [CntW-1:0] b,
                                             input logic [CntW-1:0] n);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[AW-1:0];
  endfunction

  // Shift reduced mod n: bias by 32n to make it positive, then compare-subtract
  logic [CntW-1:0] ushift;
  logic [10:0]     sred;
  always_comb begin
    sred = {{5{shift_i[5]}}, shift_i} + {n_act, 5'd0};
    for (int k = 5; k >= 0; k--) begin
      if (sred >= (11'(n_act) << k)) sred = sred - (11'(n_act) << k);
    end
    ushift = CntW'(sred);
  end
  logic [CntW-1:0] ush_q, ush_d;

  always_comb begin
    state_d = state_q; idx_d = idx_q; clr_d = clr_q; tap_d = tap_q;
    color_d = color_q; src_d = src_q; sum_d = sum_q; acc_d = acc_q;
    zero_d = zero_q; is_move_d = is_move_q; ush_d = ush_q; ov_d = ov_q;
    bel_we = 1'b0; bel_wa = idx_q[AW-1:0]; bel_wd = uni_val;
    bel_ra = idx_q[AW-1:0];
    col_we = 1'b0; col_wa = AW'(cell_req_i); col_wd = color_i;
    col_ra = idx_q[AW-1:0];
    scr_we = 1'b0; scr_wa = idx_q[AW-1:0]; scr_wd = prod_q;
    scr_ra = idx_q[AW-1:0];
    mv_we = 1'b0; mv_wa = idx_q[AW-1:0];
    mv_wd = (acc_q[33:32] != 2'd0 || acc_q[31:16] == 16'hffff && acc_q[15])
            ? 16'hffff : 16'(({2'b0, acc_q} + 36'd32768) >> 16);
    mv_ra = idx_q[AW-1:0];
    mul_a = bel_rd; mul_b = (col_rd == color_q) ? hit_q : miss_q;
    div_start = 1'b0;
    div_num = {1'b0, scr_rd, 16'd0} + {12'd0, sum_q[37:1]};
    oidx_d = 5'(idx_q); obel_d = is_move_q ? mv_rd : bel_rd;
    olast_d = (idx_q + 1'b1 == n_c); ovld_d = 1'b0;
    in_ready_o = 1'b0;

    case (state_q)
      S_CLEAR: begin
        bel_we = 1'b1; bel_wa = clr_q[AW-1:0]; bel_wd = uni_val;
        col_we = 1'b1; col_wa = clr_q[AW-1:0]; col_wd = 8'd0;
        clr_d = clr_q + 1'b1;
        if (clr_q == CntW'(MAX_CELLS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        idx_d = '0; sum_d = '0; color_d = color_i; zero_d = 1'b0;
        is_move_d = 1'b0; ush_d = ushift;
        if (in_valid_i) begin
          case (opcode_e'(opcode_i))
            OP_SENSE: state_d = S_SRD;
            OP_MOVE: begin is_move_d = 1'b1; state_d = S_MRD; tap_d = '0; end
            OP_MAP_WR: col_we = ({27'd0, cell_req_i} < MAX_CELLS);
            OP_UNIFORM: begin clr_d = '0; state_d = S_UNI; end
            default: ;
          endcase
        end
      end
      S_UNI: begin
        bel_we = 1'b1; bel_wa = clr_q[AW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == CntW'(MAX_CELLS - 1)) state_d = S_IDLE;
      end
      // Sense: read belief and color, multiply, store and sum
      S_SRD: state_d = S_SMUL;
      S_SMUL: state_d = S_SACC;
      S_SACC: begin
        scr_we = 1'b1;
        sum_d = sum_q + 38'(prod_q);
        if (idx_q + 1'b1 == n_c) begin
          idx_d = '0; state_d = S_DRD;
        end else begin
          idx_d = idx_q + 1'b1; state_d = S_SRD;
        end
      end
      S_DRD: begin
        if (sum_q == '0) begin
          zero_d = 1'b1; state_d = S_EMIT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin div_start = 1'b1; state_d = S_DWAIT; end
      S_DWAIT: begin
        if (!div_busy) begin
          bel_we = 1'b1; bel_wd = div_q;
          if (idx_q + 1'b1 == n_c) begin
            idx_d = '0; state_d = S_EMIT;
          end else begin
            idx_d = idx_q + 1'b1; state_d = S_DRD;
          end
        end
      end
      // Move: three taps through the shared multiplier
      S_MRD: begin
        src_d = wrap_add(idx_q, n_c - ush_q, n_c);
        case (tap_q)
          2'd0: bel_ra = wrap_add(idx_q, n_c - ush_q, n_c);
          2'd1: bel_ra = wrap_add(CntW'(src_q), n_c - 1'b1, n_c);
          default: bel_ra = wrap_add(CntW'(src_q), CntW'(1), n_c);
        endcase
        if (tap_q != 2'd0) src_d = src_q;
        if (tap_q == 2'd0) acc_d = '0;
        state_d = S_MMUL;
      end
      S_MMUL: begin
        mul_a = bel_rd;
        case (tap_q)
          2'd0: mul_b = exact_q;
          2'd1: mul_b = over_q;
          default: mul_b = under_q;
        endcase
        state_d = S_MWR;
      end
      S_MWR: begin
        acc_d = acc_q + 34'(prod_q);
        if (tap_q == 2'd2) begin
          tap_d = '0;
          state_d = S_MRD;
          ov_d = 1'b1;
        end else begin
          tap_d = tap_q + 1'b1;
          state_d = S_MRD;
        end
      end
      // Emit one cell per item; move copies staged value back
      S_EMIT: state_d = S_EOUT;
      S_EOUT: begin
        if (!ovld_q || out_ready_i) begin
          ovld_d = 1'b1;
          if (is_move_q) begin
            bel_we = 1'b1; bel_wd = mv_rd;
          end
          if (idx_q + 1'b1 == n_c) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1; state_d = S_EMIT;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Finished accumulator of a move cell is written to staging
    if (ov_q) begin
      mv_we = 1'b1; ov_d = 1'b0;
      if (idx_q + 1'b1 == n_c) begin
        idx_d = '0; state_d = S_EMIT;
      end else begin
        idx_d = idx_q + 1'b1;
      end
      if (state_q == S_MRD) state_d = (idx_q + 1'b1 == n_c) ? S_EMIT : S_MRD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; idx_q <= '0; tap_q <= '0;
      ovld_q <= 1'b0; ov_q <= 1'b0; zero_q <= 1'b0; is_move_q <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; idx_q <= idx_d; tap_q <= tap_d;
      ov_q <= ov_d; zero_q <= zero_d; is_move_q <= is_move_d;
      if (ovld_d) ovld_q <= 1'b1;
      else if (out_ready_i) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d; src_q <= src_d; sum_q <= sum_d; acc_q <= acc_d;
    ush_q <= ush_d;
    if (ovld_d) begin
      cell_index_o <= oidx_d; belief_o <= obel_d;
      zero_sum_o <= zero_q; last_o <= olast_d;
    end
  end

  assign out_valid_o = ovld_q;

  property p_busy;
    @(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> state_q == S_IDLE;
  endproperty
  a_busy: assert property (p_busy) else $error("ready outside idle");

  property p_emit_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      ovld_q && !out_ready_i |=> ovld_q && $stable(belief_o);
  endproperty
  a_emit_hold: assert property (p_emit_hold) else $error("result dropped");

  property p_idx;
    @(posedge clk_i) disable iff (!rst_ni) idx_q < n_c || state_q == S_IDLE;
  endproperty
  a_idx: assert property (p_idx) else $error("cell index out of range");
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the histogram localization filter
// Drives sense, move, map write and uniform items over valid/ready with random
// idle bursts, predicts every belief vector in a local copy of the filter and
// checks each result item in order against it.
// ----------------------------------------------------------------------------
module tb_top
  import hlf_pkg::*;
;

  localparam int unsigned MaxCells  = 32;
  localparam int unsigned CycLimit  = 3000000;
  localparam int unsigned DrainCyc  = 200;
  localparam int unsigned SettleCyc = 100;

  typedef struct {
    logic [4:0]  idx;
    logic [15:0] belief;
    logic        zero;
    logic        last;
  } cell_res_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          opcode_i;
  logic [7:0]          color_i;
  logic signed [5:0]   shift_i;
  logic [4:0]          cell_req_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [4:0]          cell_index_o;
  logic [15:0]         belief_o;
  logic                zero_sum_o;
  logic                last_o;

  histogram_localization_filter u_dut (.*);

  // Local copy of the filter state and registers
  logic [5:0]  cells_r;
  logic [15:0] hit_r, miss_r, exact_r, over_r, under_r;
  logic [15:0] belief_m [MaxCells];
  logic [7:0]  cmap_m   [MaxCells];

  cell_res_t   belief_q[$];
  int unsigned err_cnt;
  int unsigned cyc_cnt;
  bit          no_idle;
  int unsigned ready_hold;

  // Clock
  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // Run limit
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CycLimit) begin
      $display("histogram_localization_filter test failed");
      $finish;
    end
  end

  // Result side: random stall bursts
  always @(negedge clk_i) begin
    if (no_idle) begin
      out_ready_i <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold  <= ready_hold - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      ready_hold  <= $urandom_range(0, 4);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    cell_res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (belief_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result item: idx %0d belief %0d zero %0b last %0b",
                   cell_index_o, belief_o, zero_sum_o, last_o);
      end else begin
        exp_r = belief_q.pop_front();
        if (exp_r.idx !== cell_index_o || exp_r.belief !== belief_o ||
            exp_r.zero !== zero_sum_o || exp_r.last !== last_o) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp idx/belief/zero/last %0d %0d %0b %0b, got %0d %0d %0b %0b",
                     exp_r.idx, exp_r.belief, exp_r.zero, exp_r.last,
                     cell_index_o, belief_o, zero_sum_o, last_o);
        end
      end
    end
  end

  function automatic int unsigned cells_active();
    int unsigned n;
    n = cells_r;
    if (n == 0) n = 1;
    if (n > MaxCells) n = MaxCells;
    return n;
  endfunction

  function automatic logic [15:0] clip16(longint unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic queue_vector(int unsigned n, logic zero);
    cell_res_t r;
    for (int unsigned i = 0; i < n; i++) begin
      r.idx    = i[4:0];
      r.belief = belief_m[i];
      r.zero   = zero;
      r.last   = (i + 1 == n);
      belief_q = {belief_q, r};
    end
  endtask

  // Predict the effect of one accepted item
  task automatic predict_filter(opcode_e op, logic [7:0] color, logic signed [5:0] shift,
                                logic [4:0] cell_sel);
    int unsigned     n;
    longint unsigned prod [MaxCells];
    longint unsigned sum;
    longint unsigned acc;
    logic [15:0]     prev [MaxCells];
    int              r;
    int unsigned     src, far_i, near_i;
    n = cells_active();
    case (op)
      OP_SENSE: begin
        sum = 0;
        for (int unsigned i = 0; i < n; i++) begin
          prod[i] = belief_m[i] * ((cmap_m[i] == color) ? hit_r : miss_r);
          sum += prod[i];
        end
        if (sum == 0) begin
          queue_vector(n, 1'b1);
        end else begin
          for (int unsigned i = 0; i < n; i++)
            belief_m[i] = clip16(((prod[i] << 16) + (sum >> 1)) / sum);
          queue_vector(n, 1'b0);
        end
      end
      OP_MOVE: begin
        r = int'(shift) % int'(n);
        if (r < 0) r += n;
        prev = belief_m;
        for (int unsigned i = 0; i < n; i++) begin
          src    = (i + n - r) % n;
          far_i  = (src + n - 1) % n;
          near_i = (src + 1) % n;
          acc = longint'(exact_r) * prev[src] + longint'(over_r) * prev[far_i]
              + longint'(under_r) * prev[near_i];
          belief_m[i] = clip16((acc + 32768) >> 16);
        end
        queue_vector(n, 1'b0);
      end
      OP_MAP_WR: cmap_m[cell_sel] = color;
      default: begin
        for (int unsigned i = 0; i < MaxCells; i++)
          belief_m[i] = (n == 1) ? 16'hFFFF : 16'(65536 / n);
      end
    endcase
  endtask

  // Send one item, with an optional random gap before it
  task automatic send_item(opcode_e op, logic [7:0] color, logic signed [5:0] shift,
                           logic [4:0] cell_sel);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    opcode_i   = op;
    color_i    = color;
    shift_i    = shift;
    cell_req_i = cell_sel;
    do @(posedge clk_i); while (!in_ready_o);
    predict_filter(op, color, shift, cell_sel);
  endtask

  // Wait for all results, then let any item without results finish
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (belief_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    case (idx)
      REG_CELLS: cells_r = val[5:0];
      REG_HIT:   hit_r   = val;
      REG_MISS:  miss_r  = val;
      REG_EXACT: exact_r = val;
      REG_OVER:  over_r  = val;
      default:   under_r = val;
    endcase
  endtask

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_weights(logic [15:0] h, logic [15:0] m, logic [15:0] e,
                               logic [15:0] o, logic [15:0] u);
    cfg_write(REG_HIT, h);
    cfg_write(REG_MISS, m);
    cfg_write(REG_EXACT, e);
    cfg_write(REG_OVER, o);
    cfg_write(REG_UNDER, u);
  endtask

  // Reset values, map edges and every shift extreme at five cells
  task automatic test_directed();
    send_item(OP_SENSE, 8'd0, 6'sd0, 5'd0);
    send_item(OP_MAP_WR, 8'hFF, 6'sd0, 5'd0);
    send_item(OP_MAP_WR, 8'h80, 6'sd0, 5'd4);
    send_item(OP_MAP_WR, 8'h55, 6'sd0, 5'd31);
    send_item(OP_SENSE, 8'hFF, 6'sd0, 5'd0);
    send_item(OP_SENSE, 8'h80, 6'sd0, 5'd0);
    send_item(OP_SENSE, 8'h55, 6'sd0, 5'd0);
    send_item(OP_MOVE, 8'd0, 6'sd0, 5'd0);
    send_item(OP_MOVE, 8'd0, 6'sd1, 5'd0);
    send_item(OP_MOVE, 8'd0, -6'sd1, 5'd0);
    send_item(OP_MOVE, 8'd0, 6'sd31, 5'd0);
    send_item(OP_MOVE, 8'd0, -6'sd31, 5'd0);
    send_item(OP_MOVE, 8'd0, -6'sd32, 5'd0);
    send_item(OP_UNIFORM, 8'hFF, 6'sd31, 5'd31);
    send_item(OP_SENSE, 8'h00, 6'sd0, 5'd0);
    wait_idle();
  endtask

  // Zero likelihoods give a zero sum; full weights saturate
  task automatic test_weight_extremes();
    write_weights(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_SENSE, 8'hFF, 6'sd0, 5'd0);
    send_item(OP_MOVE, 8'd0, 6'sd2, 5'd0);
    send_item(OP_SENSE, 8'hFF, 6'sd0, 5'd0);
    wait_idle();
    write_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_UNIFORM, 8'd0, 6'sd0, 5'd0);
    send_item(OP_MOVE, 8'd0, 6'sd3, 5'd0);
    send_item(OP_SENSE, 8'hFF, 6'sd0, 5'd0);
    wait_idle();
  endtask

  // Cell counts of zero, one, full and beyond the store
  task automatic test_cell_counts();
    logic [15:0] cnt_list [5] = '{16'd0, 16'd1, 16'd32, 16'd33, 16'd63};
    write_weights(HitRst, MissRst, ExactRst, OverRst, UnderRst);
    foreach (cnt_list[k]) begin
      cfg_write(REG_CELLS, cnt_list[k]);
      send_item(OP_UNIFORM, 8'd0, 6'sd0, 5'd0);
      send_item(OP_SENSE, 8'h80, 6'sd0, 5'd0);
      send_item(OP_MOVE, 8'd0, -6'sd5, 5'd0);
      wait_idle();
    end
  endtask

  // Random phases with random settings, mostly few cells
  task automatic test_random();
    int unsigned items;
    int unsigned pick;
    logic [7:0]  col;
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 8) no_idle = 1'b1;
      cfg_write(REG_CELLS, (ph == 4) ? 16'd32 : 16'($urandom_range(1, 8)));
      write_weights(pick_weight(), pick_weight(), pick_weight(), pick_weight(),
                    pick_weight());
      items = (ph == 4) ? 20 : 52;
      for (int unsigned k = 0; k < items; k++) begin
        pick = $urandom_range(0, 99);
        col  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        if (pick < 35)
          send_item(OP_SENSE, col, 6'($urandom), 5'($urandom));
        else if (pick < 70)
          send_item(OP_MOVE, 8'($urandom), 6'($urandom), 5'($urandom));
        else if (pick < 92)
          send_item(OP_MAP_WR, col, 6'($urandom), 5'($urandom));
        else
          send_item(OP_UNIFORM, 8'($urandom), 6'($urandom), 5'($urandom));
        // hold off until the filter has drained once per phase
        if (k == items / 2) wait_idle();
      end
      wait_idle();
    end
  endtask

  initial begin
    err_cnt     = 0;
    cyc_cnt     = 0;
    no_idle     = 1'b0;
    ready_hold  = 0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_CELLS;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    opcode_i    = OP_SENSE;
    color_i     = '0;
    shift_i     = '0;
    cell_req_i  = '0;
    out_ready_i = 1'b1;
    cells_r     = CellsRst;
    hit_r       = HitRst;
    miss_r      = MissRst;
    exact_r     = ExactRst;
    over_r      = OverRst;
    under_r     = UnderRst;
    for (int i = 0; i < MaxCells; i++) begin
      belief_m[i] = 16'(65536 / 5);
      cmap_m[i]   = '0;
    end
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    // let the reset sweep finish before any register write
    repeat (SettleCyc) @(posedge clk_i);

    test_directed();
    test_weight_extremes();
    test_cell_counts();
    test_random();

    repeat (DrainCyc) @(posedge clk_i);
    if (err_cnt == 0 && belief_q.size() == 0) begin
      $display("histogram_localization_filter test passed");
    end else begin
      $display("histogram_localization_filter test failed");
    end
    $finish;
  end

endmodule
